### hdl/frv_pkg.sv
// frv_pkg: shared types, codes and constants of the frame receiver validator
// holds the byte-wide crc update used by the checker; no dependencies
package frv_pkg;

  // frame layout bytes
  localparam logic [7:0] START_A = 8'h18;
  localparam logic [7:0] START_B = 8'h02;
  localparam logic [7:0] TERM_A  = 8'hE7;
  localparam logic [7:0] TERM_B  = 8'hFD;

  // header plus trailer bytes, and frame size for a zero length byte
  localparam logic [8:0] OVERHEAD  = 9'd9;
  localparam logic [8:0] MAX_TOTAL = 9'd265;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // configuration reset values
  localparam logic [7:0]  STATION_RST = 8'hF3;
  localparam logic [15:0] POLY_RST    = 16'h1021;
  localparam logic [7:0]  TIMEOUT_RST = 8'd56;

  // register indexes on the configuration port
  localparam logic [1:0] REG_STATION = 2'd0;
  localparam logic [1:0] REG_POLY    = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  typedef enum logic [2:0] {
    STAT_VALID,
    STAT_BAD_START,
    STAT_WRONG_STATION,
    STAT_BAD_CRC,
    STAT_BAD_TERM
  } status_e;

  typedef struct packed {
    logic [7:0]  station;
    logic [15:0] poly;
    logic [7:0]  timeout;
  } cfg_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    status_e    status;
    logic       timed_out;
    logic [7:0] source_station;
    logic [7:0] command;
    logic [8:0] data_length;
  } result_t;

  // eight msb-first shift steps of the crc register with one data byte
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] data,
                                           logic [15:0] poly);
    logic [15:0] c;
    logic        top;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      top = c[15];
      c   = {c[14:0], data[7-i]};
      if (top) begin
        c = c ^ poly;
      end
    end
    return c;
  endfunction

endpackage

### hdl/frv_apb_regs.sv
// frv_apb_regs: apb configuration registers of the frame receiver validator
// depends on frv_pkg for the register indexes and reset values
module frv_apb_regs import frv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [1:0] idx;
  logic       wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_STATION: cfg_d.station = pwdata[7:0];
        REG_POLY:    cfg_d.poly    = pwdata[15:0];
        REG_TIMEOUT: cfg_d.timeout = pwdata[7:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.station <= STATION_RST;
      cfg_q.poly    <= POLY_RST;
      cfg_q.timeout <= TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_STATION: prdata = {24'd0, cfg_q.station};
      REG_POLY:    prdata = {16'd0, cfg_q.poly};
      REG_TIMEOUT: prdata = {24'd0, cfg_q.timeout};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

### hdl/frv_in_reg.sv
// frv_in_reg: input register stage that captures one beat per cycle while ready
// depends on frv_pkg for the item type
module frv_in_reg import frv_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  valid_o,
  input  logic  advance_i,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  // free when empty or when the held beat moves on this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

### hdl/frv_checker.sv
// frv_checker: frame state, byte checks, crc update and verdict forming
// depends on frv_pkg for codes, constants and the crc step function
module frv_checker import frv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    advance_i,
  input  item_t   item_i,
  output logic    emit_o,
  output result_t result_o
);

  logic [8:0]  pos_q, pos_d;
  logic [8:0]  total_q, total_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  chk_hi_q, chk_hi_d;
  status_e     err_q, err_d;
  logic [7:0]  src_q, src_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  idle_q, idle_d;

  logic [9:0]  pos_x, total_x;
  logic [7:0]  idle_inc;
  logic [7:0]  b;
  logic        in_body, at_chk_hi, at_chk_lo, at_term_a, at_term_b;
  logic        note;
  status_e     note_code;
  status_e     err_new;
  logic [7:0]  feed_data;
  logic [15:0] feed_out;
  logic [8:0]  len_out;
  logic        clear;

  assign b       = item_i.rx_byte;
  assign pos_x   = {1'b0, pos_q};
  assign total_x = {1'b0, total_q};
  assign idle_inc = idle_q + 8'd1;

  // where in the frame this byte falls
  assign in_body   = (pos_q <= 9'd4) || ((pos_x + 10'd4) < total_x);
  assign at_chk_hi = !in_body && ((pos_x + 10'd4) == total_x);
  assign at_chk_lo = !in_body && ((pos_x + 10'd3) == total_x);
  assign at_term_a = !in_body && ((pos_x + 10'd2) == total_x);
  assign at_term_b = !in_body && ((pos_x + 10'd1) == total_x);

  // one shared byte-wide crc step; the two augment bytes go in as zeros
  assign feed_data = in_body ? b : 8'd0;
  assign feed_out  = crc_feed(crc_q, feed_data, cfg_i.poly);

  assign len_out = (total_q >= OVERHEAD) ? (total_q - OVERHEAD) : 9'd0;

  // check each field in frame order
  always_comb begin
    note      = 1'b0;
    note_code = STAT_VALID;
    if (pos_q == 9'd0 && b != START_A) begin
      note = 1'b1; note_code = STAT_BAD_START;
    end else if (pos_q == 9'd1 && b != START_B) begin
      note = 1'b1; note_code = STAT_BAD_START;
    end else if (pos_q == 9'd2 && b != cfg_i.station) begin
      note = 1'b1; note_code = STAT_WRONG_STATION;
    end else if (at_chk_lo && feed_out != {chk_hi_q, b}) begin
      note = 1'b1; note_code = STAT_BAD_CRC;
    end else if (at_term_a && b != TERM_A) begin
      note = 1'b1; note_code = STAT_BAD_TERM;
    end else if (at_term_b && b != TERM_B) begin
      note = 1'b1; note_code = STAT_BAD_TERM;
    end
    err_new = (note && err_q == STAT_VALID) ? note_code : err_q;
  end

  // next state and verdict
  always_comb begin
    pos_d    = pos_q;
    total_d  = total_q;
    crc_d    = crc_q;
    chk_hi_d = chk_hi_q;
    err_d    = err_q;
    src_d    = src_q;
    cmd_d    = cmd_q;
    idle_d   = idle_q;
    clear    = 1'b0;
    emit_o   = 1'b0;
    result_o.status         = err_new;
    result_o.timed_out      = 1'b0;
    result_o.source_station = src_q;
    result_o.command        = cmd_q;
    result_o.data_length    = len_out;
    if (item_i.mode) begin
      // timer tick, only counts while a frame is open
      if (pos_q != 9'd0) begin
        idle_d = idle_inc;
        if (idle_inc >= cfg_i.timeout) begin
          emit_o             = 1'b1;
          clear              = 1'b1;
          result_o.status    = STAT_BAD_TERM;
          result_o.timed_out = 1'b1;
        end
      end
    end else begin
      idle_d = 8'd0;
      err_d  = err_new;
      if (pos_q == 9'd3) begin
        src_d = b;
      end
      if (pos_q == 9'd4) begin
        total_d = (b == 8'd0) ? MAX_TOTAL : ({1'b0, b} + OVERHEAD);
      end
      if (pos_q == 9'd5) begin
        cmd_d = b;
      end
      if (in_body || at_chk_hi || at_chk_lo) begin
        crc_d = feed_out;
      end
      if (at_chk_hi) begin
        chk_hi_d = b;
      end
      if (total_q != 9'd0 && at_term_b) begin
        emit_o = 1'b1;
        clear  = 1'b1;
      end else begin
        pos_d = pos_q + 9'd1;
      end
    end
    if (clear) begin
      pos_d    = 9'd0;
      total_d  = 9'd0;
      crc_d    = CRC_INIT;
      chk_hi_d = 8'd0;
      err_d    = STAT_VALID;
      src_d    = 8'd0;
      cmd_d    = 8'd0;
      idle_d   = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 9'd0;
      total_q  <= 9'd0;
      crc_q    <= CRC_INIT;
      chk_hi_q <= 8'd0;
      err_q    <= STAT_VALID;
      src_q    <= 8'd0;
      cmd_q    <= 8'd0;
      idle_q   <= 8'd0;
    end else if (advance_i) begin
      pos_q    <= pos_d;
      total_q  <= total_d;
      crc_q    <= crc_d;
      chk_hi_q <= chk_hi_d;
      err_q    <= err_d;
      src_q    <= src_d;
      cmd_q    <= cmd_d;
      idle_q   <= idle_d;
    end
  end

endmodule

### hdl/frv_out_reg.sv
// frv_out_reg: result register that holds a verdict until it is taken
// depends on frv_pkg for the result type
module frv_out_reg import frv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  // room for a new verdict when empty or when the held one leaves now
  assign free_o   = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      result_q <= result_i;
    end
  end

endmodule

### hdl/frame_receiver_validator_unit.sv
// frame_receiver_validator_unit: top level of the serial frame checker
// depends on frv_pkg, frv_apb_regs, frv_in_reg, frv_checker and frv_out_reg
//
// usage
//   slave stream: one beat per received byte (tuser = 0) or per timer tick
//   (tuser = 1). frames are 0x18 0x02 dst src len data.. crc_hi crc_lo
//   0xE7 0xFD, len 0 meaning 256 data bytes; crc is start 0xFFFF, msb first,
//   augmented by 16 zero bits.
//   master stream: one verdict beat at each frame end or idle timeout.
//   apb port: station address at 0x0, crc polynomial at 0x4, timeout at 0x8,
//   written only while no beat is in flight.
// timing
//   a beat is registered in the input register, then checked; tvalid rises once
//   the verdict of the closing beat is loaded into the result register.
//   one beat per cycle sustained while no verdict waits on m_axis_tready; crc is byte-wide.
// reset
//   clears the frame state and the valid flags of both stage registers, and loads default config.
// stall
//   a held verdict blocks the checker stage only; the input register still
//   takes one beat, then tready drops until the master side takes the verdict.
module frame_receiver_validator_unit import frv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [2:0] status, [10:3] source_station,
                                      // [18:11] command, [27:19] data_length
  output logic        m_axis_tuser,   // [0] timed_out
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  item_t   in_item, item;
  logic    item_valid;
  logic    advance;
  logic    emit;
  logic    out_free;
  result_t result, out_result;

  assign in_item.mode    = s_axis_tuser;
  assign in_item.rx_byte = s_axis_tdata;

  // checker stage moves when an item waits and the result slot can take it
  assign advance = item_valid && out_free;

  frv_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  frv_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .valid_o    (item_valid),
    .advance_i  (advance),
    .item_o     (item)
  );

  frv_checker u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .advance_i (advance),
    .item_i    (item),
    .emit_o    (emit),
    .result_o  (result)
  );

  frv_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && emit),
    .result_i (result),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  // pack the verdict beat
  assign m_axis_tdata = {4'd0, out_result.data_length, out_result.command,
                         out_result.source_station, out_result.status};
  assign m_axis_tuser = out_result.timed_out;

endmodule
